### hw/rtl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

    // Width of the encoder counters; deltas wrap modulo 2^COUNT_WIDTH.
    localparam int COUNT_WIDTH = 32;

    // CORDIC iteration count; the arctangent table has 24 entries.
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_TABLE_LEN = 24;
    localparam int CORDIC_RUN       = (CORDIC_STEPS < CORDIC_TABLE_LEN) ?
                                      CORDIC_STEPS : CORDIC_TABLE_LEN;
    localparam int CORDIC_IDX_W     = 5;

    // Fixed CORDIC gain compensation, 0.6072529 in Q2.30.
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Radians to binary angle, 65536 / (2 pi) scaled by 2^32 / 2^16.
    localparam logic [29:0] TURN_K = 30'd683565276;

    // Microseconds per second, for the velocity division.
    localparam logic [19:0] VEL_SCALE = 20'd1000000;

    // Configuration register map.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_PER_TICK    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_WHEEL_BASE = 2'd1;
    localparam logic [31:0] LPT_RESET = 32'd65536;
    localparam logic [31:0] IWB_RESET = 32'd131072;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [31:0] ticks_left;
        logic signed [31:0] ticks_right;
        logic [23:0]        elapsed_us;
    } work_item_t;

    typedef struct packed {
        logic [31:0] length_per_tick;
        logic [31:0] inverse_wheel_base;
    } cfg_t;

    typedef struct packed {
        logic [31:0] ang_velocity;
        logic [31:0] lin_velocity;
        logic [15:0] heading_angle;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } result_t;

    // Arctangent of 2^-i as a fraction of a full turn, scaled by 2^32.
    function automatic logic [31:0] atan_turn(input logic [CORDIC_IDX_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ddo_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_front
    import ddo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] left_count,
    input  wire logic [31:0] right_count,
    input  wire logic [23:0] elapsed_us,
    input  wire logic        queue_full,
    output logic             push,
    output work_item_t       push_item
);

    logic [31:0] prev_left_reg;
    logic [31:0] prev_right_reg;
    logic [COUNT_WIDTH-1:0] dl;
    logic [COUNT_WIDTH-1:0] dr;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    // Count deltas wrap at the counter width and read as signed.
    assign dl = left_count[COUNT_WIDTH-1:0] - prev_left_reg[COUNT_WIDTH-1:0];
    assign dr = right_count[COUNT_WIDTH-1:0] - prev_right_reg[COUNT_WIDTH-1:0];

    always_comb
    begin
        push_item.ticks_left  = 32'($signed(dl));
        push_item.ticks_right = 32'($signed(dr));
        push_item.elapsed_us  = elapsed_us;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= 32'd0;
            prev_right_reg <= 32'd0;
        end
        else if (push)
        begin
            prev_left_reg  <= left_count;
            prev_right_reg <= right_count;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ddo_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_queue
    import ddo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  work_item_t push_item,
    input  wire logic  pop,
    output work_item_t pop_item,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    work_item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [PTR_W:0]        count_reg;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ddo_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_back
    import ddo_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  cfg_t       cfg,
    input  wire logic  queue_empty,
    input  work_item_t queue_item,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_result
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DL   = 5'd1;
    localparam logic [4:0] ST_DR   = 5'd2;
    localparam logic [4:0] ST_DIFF = 5'd3;
    localparam logic [4:0] ST_ABS  = 5'd4;
    localparam logic [4:0] ST_TM1  = 5'd5;
    localparam logic [4:0] ST_TM2  = 5'd6;
    localparam logic [4:0] ST_TM3  = 5'd7;
    localparam logic [4:0] ST_B1   = 5'd8;
    localparam logic [4:0] ST_B2   = 5'd9;
    localparam logic [4:0] ST_B3   = 5'd10;
    localparam logic [4:0] ST_CORD = 5'd11;
    localparam logic [4:0] ST_X    = 5'd12;
    localparam logic [4:0] ST_Y    = 5'd13;
    localparam logic [4:0] ST_V    = 5'd14;
    localparam logic [4:0] ST_DIV0 = 5'd15;
    localparam logic [4:0] ST_DIV  = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;

    logic [4:0]               state_reg;
    work_item_t               item_reg;
    logic signed [32:0]       mul_a;
    logic signed [33:0]       mul_b;
    logic signed [66:0]       prod_reg;
    logic signed [31:0]       dl_reg;
    logic signed [31:0]       dr_reg;
    logic signed [31:0]       dist_reg;
    logic                     tneg_reg;
    logic [32:0]              amag_reg;
    logic [49:0]              t1_reg;
    logic [49:0]              m_reg;
    logic [23:0]              p_lo_reg;
    logic [15:0]              heading_reg;
    logic                     flip_reg;
    logic [31:0]              z_reg;
    logic signed [33:0]       x_reg;
    logic signed [33:0]       y_reg;
    logic [CORDIC_IDX_W-1:0]  iter_reg;
    logic [31:0]              acc_x_reg;
    logic [31:0]              acc_y_reg;
    logic [63:0]              lin_num_reg;
    logic [63:0]              ang_num_reg;
    logic                     lin_over_reg;
    logic                     ang_over_reg;
    logic [23:0]              lin_rem_reg;
    logic [23:0]              ang_rem_reg;
    logic [31:0]              lin_q_reg;
    logic [31:0]              ang_q_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic signed [32:0]       sum_w;
    logic signed [32:0]       diff_w;
    logic [55:0]              low_w;
    logic [15:0]              bam_w;
    logic [15:0]              dh_w;
    logic [15:0]              h_w;
    logic signed [33:0]       xs_w;
    logic signed [33:0]       ys_w;
    logic [31:0]              dist_mag_w;
    logic [40:0]              m_clamp_w;
    logic [24:0]              lin_trial_w;
    logic [24:0]              ang_trial_w;
    logic                     lin_bit_w;
    logic                     ang_bit_w;
    logic                     us_zero_w;
    logic                     out_free_w;

    // Saturate a product shifted right by 16 to the signed 32-bit range.
    function automatic logic signed [31:0] sat_q16(input logic signed [66:0] p);
        logic signed [50:0] s;
        s = p[66:16];
        if (s > 51'sh7FFFFFFF)
        begin
            return 32'sh7FFFFFFF;
        end
        if (s < -51'sh80000000)
        begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    // Signed velocity from a sign, an overflow flag and a 32-bit quotient, or zero for a zero interval.
    function automatic logic [31:0] vel_of(input logic neg, input logic over,
                                           input logic [31:0] q, input logic us_zero);
        logic [31:0] v;
        if (us_zero)
        begin
            v = 32'd0;
        end
        else if (!neg)
        begin
            v = (over || q > 32'h7FFFFFFF) ? 32'h7FFFFFFF : q;
        end
        else
        begin
            v = 32'd0 - ((over || q > 32'h80000000) ? 32'h80000000 : q);
        end
        return v;
    endfunction

    assign us_zero_w  = (item_reg.elapsed_us == 24'd0);
    assign out_free_w = !out_valid_reg || out_ready;
    assign pop        = (state_reg == ST_IDLE) && !queue_empty;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DL:
            begin
                mul_a = 33'(item_reg.ticks_left);
                mul_b = $signed({2'b00, cfg.length_per_tick});
            end
            ST_DR:
            begin
                mul_a = 33'(item_reg.ticks_right);
                mul_b = $signed({2'b00, cfg.length_per_tick});
            end
            ST_TM1:
            begin
                mul_a = $signed({16'd0, amag_reg[32:16]});
                mul_b = $signed({2'b00, cfg.inverse_wheel_base});
            end
            ST_TM2:
            begin
                mul_a = $signed({17'd0, amag_reg[15:0]});
                mul_b = $signed({2'b00, cfg.inverse_wheel_base});
            end
            ST_B1:
            begin
                mul_a = $signed({7'd0, m_reg[49:24]});
                mul_b = $signed({4'd0, TURN_K});
            end
            ST_B2:
            begin
                mul_a = $signed({9'd0, m_reg[23:0]});
                mul_b = $signed({4'd0, TURN_K});
            end
            ST_X:
            begin
                mul_a = 33'(dist_reg);
                mul_b = flip_reg ? -x_reg : x_reg;
            end
            ST_Y:
            begin
                mul_a = 33'(dist_reg);
                mul_b = flip_reg ? -y_reg : y_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        sum_w       = 33'(dl_reg) + 33'(dr_reg);
        diff_w      = 33'(dr_reg) - 33'(dl_reg);
        low_w       = {24'd0, p_lo_reg[7:0], 24'd0} + 56'(prod_reg[54:0]);
        bam_w       = p_lo_reg[23:8] + low_w[47:32];
        dh_w        = tneg_reg ? (16'd0 - bam_w) : bam_w;
        h_w         = heading_reg + dh_w;
        xs_w        = x_reg >>> iter_reg;
        ys_w        = y_reg >>> iter_reg;
        dist_mag_w  = dist_reg[31] ? (32'd0 - 32'(dist_reg)) : 32'(dist_reg);
        m_clamp_w   = (m_reg > 50'h100_0000_0000) ? 41'h100_0000_0000 : m_reg[40:0];
        lin_trial_w = {lin_rem_reg, lin_q_reg[31]};
        ang_trial_w = {ang_rem_reg, ang_q_reg[31]};
        lin_bit_w   = (lin_trial_w >= {1'b0, item_reg.elapsed_us});
        ang_bit_w   = (ang_trial_w >= {1'b0, item_reg.elapsed_us});
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 67'(mul_a * mul_b);
        case (state_reg)
            ST_IDLE:
            begin
                item_reg <= queue_item;
            end
            ST_DR:
            begin
                dl_reg <= sat_q16(prod_reg);
            end
            ST_DIFF:
            begin
                dr_reg <= sat_q16(prod_reg);
            end
            ST_ABS:
            begin
                dist_reg <= sum_w[32:1];
                tneg_reg <= diff_w[32];
                amag_reg <= diff_w[32] ? 33'(-diff_w) : 33'(diff_w);
            end
            ST_TM2:
            begin
                t1_reg <= prod_reg[49:0];
            end
            ST_TM3:
            begin
                m_reg <= t1_reg + {16'd0, prod_reg[49:16]};
            end
            ST_B2:
            begin
                p_lo_reg <= prod_reg[23:0];
            end
            ST_B3:
            begin
                flip_reg <= h_w[15] ^ h_w[14];
                z_reg    <= {h_w[14], h_w[14:0], 16'd0};
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
            end
            ST_CORD:
            begin
                if (!z_reg[31])
                begin
                    x_reg <= x_reg - ys_w;
                    y_reg <= y_reg + xs_w;
                    z_reg <= z_reg - atan_turn(iter_reg);
                end
                else
                begin
                    x_reg <= x_reg + ys_w;
                    y_reg <= y_reg - xs_w;
                    z_reg <= z_reg + atan_turn(iter_reg);
                end
            end
            ST_V:
            begin
                lin_num_reg <= 64'(dist_mag_w * VEL_SCALE);
                ang_num_reg <= 64'(m_clamp_w * VEL_SCALE);
            end
            ST_DIV0:
            begin
                lin_over_reg <= (lin_num_reg[63:32] >= {8'd0, item_reg.elapsed_us});
                ang_over_reg <= (ang_num_reg[63:32] >= {8'd0, item_reg.elapsed_us});
                lin_rem_reg  <= lin_num_reg[55:32];
                ang_rem_reg  <= ang_num_reg[55:32];
                lin_q_reg    <= lin_num_reg[31:0];
                ang_q_reg    <= ang_num_reg[31:0];
            end
            ST_DIV:
            begin
                lin_rem_reg <= lin_bit_w ? 24'(lin_trial_w - {1'b0, item_reg.elapsed_us})
                                         : lin_trial_w[23:0];
                ang_rem_reg <= ang_bit_w ? 24'(ang_trial_w - {1'b0, item_reg.elapsed_us})
                                         : ang_trial_w[23:0];
                lin_q_reg   <= {lin_q_reg[30:0], lin_bit_w};
                ang_q_reg   <= {ang_q_reg[30:0], ang_bit_w};
            end
            ST_OUT:
            begin
                if (out_free_w)
                begin
                    out_reg.pos_x         <= acc_x_reg;
                    out_reg.pos_y         <= acc_y_reg;
                    out_reg.heading_angle <= heading_reg;
                    out_reg.lin_velocity  <= vel_of(dist_reg[31], lin_over_reg,
                                                    lin_q_reg, us_zero_w);
                    out_reg.ang_velocity  <= vel_of(tneg_reg, ang_over_reg,
                                                    ang_q_reg, us_zero_w);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            heading_reg   <= 16'd0;
            acc_x_reg     <= 32'd0;
            acc_y_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_OUT) && out_free_w)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        state_reg <= ST_DL;
                    end
                end
                ST_DL:   state_reg <= ST_DR;
                ST_DR:   state_reg <= ST_DIFF;
                ST_DIFF: state_reg <= ST_ABS;
                ST_ABS:  state_reg <= ST_TM1;
                ST_TM1:  state_reg <= ST_TM2;
                ST_TM2:  state_reg <= ST_TM3;
                ST_TM3:  state_reg <= ST_B1;
                ST_B1:   state_reg <= ST_B2;
                ST_B2:   state_reg <= ST_B3;
                ST_B3:
                begin
                    heading_reg <= h_w;
                    iter_reg    <= '0;
                    state_reg   <= ST_CORD;
                end
                ST_CORD:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == CORDIC_IDX_W'(CORDIC_RUN - 1))
                    begin
                        state_reg <= ST_X;
                    end
                end
                ST_X:    state_reg <= ST_Y;
                ST_Y:
                begin
                    acc_x_reg <= acc_x_reg + prod_reg[61:30];
                    state_reg <= ST_V;
                end
                ST_V:
                begin
                    acc_y_reg <= acc_y_reg + prod_reg[61:30];
                    state_reg <= ST_DIV0;
                end
                ST_DIV0:
                begin
                    iter_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == '1)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free_w)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/differential_drive_odometry.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  left_count, right_count, elapsed_us
// m_*       out        m_tvalid / m_tready  pos_x, pos_y, heading_angle,
//                                           lin_velocity, ang_velocity
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each transaction passes through the back end in order: it is taken from the
// queue, then come the shared multiplier steps and heading update, CORDIC_STEPS
// (16) rotation iterations, the position update and divider setup, the radix-2
// velocity dividers and the load of the output register, which waits for a free
// output; the result is offered on the following cycle.
// The front end holds the previous counts and can take two transactions
// ahead of the back end through a two-entry queue.
// Reset clears the counts, the pose, the queue and the output valid flag, and
// loads the configuration reset values. A stalled output holds its data while
// the next transaction is already being worked on, up to its output step.

module differential_drive_odometry
    import ddo_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // left_count[31:0], right_count[63:32], elapsed_us[87:64]
    input  wire logic [87:0]            s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pos_x[31:0], pos_y[63:32], heading_angle[79:64],
    // lin_velocity[111:80], ang_velocity[143:112]
    output logic [143:0]                m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);

    cfg_t       cfg_reg;
    logic       queue_full;
    logic       queue_empty;
    logic       push;
    logic       pop;
    work_item_t push_item;
    work_item_t pop_item;
    result_t    result;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.length_per_tick    <= LPT_RESET;
            cfg_reg.inverse_wheel_base <= IWB_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LENGTH_PER_TICK:    cfg_reg.length_per_tick    <= cfg_data;
                CFG_INVERSE_WHEEL_BASE: cfg_reg.inverse_wheel_base <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The front end turns absolute counts into tick deltas.
    ddo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .left_count  (s_tdata[31:0]),
        .right_count (s_tdata[63:32]),
        .elapsed_us  (s_tdata[87:64]),
        .queue_full  (queue_full),
        .push        (push),
        .push_item   (push_item)
    );

    ddo_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // The back end scales, rotates, accumulates and divides.
    ddo_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .queue_item  (pop_item),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    assign m_tdata = result;

endmodule

`default_nettype wire

### hw/rtl/ddo_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_checker
    import ddo_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata,
    input wire logic         cfg_ready
);

    // A held result must stay offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // The queue can only fill after an accepted transaction.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input ready fell without a transaction");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
